[hw/rtl/alle_pkg.sv]
// Package for the linked list engine: widths, codes and shared types.
// Used by the node store and the core; depends on nothing.
package alle_pkg;
    localparam int NodeCountDef = 64;
    localparam int LinkW = 7;
    localparam logic [LinkW-1:0] NullSlot = 7'd127;
    localparam int OpW = 3;
    localparam int ValW = 32;
    localparam int StatW = 2;

    localparam logic [OpW-1:0] OP_APPEND = 3'd0;
    localparam logic [OpW-1:0] OP_INS_AFTER = 3'd1;
    localparam logic [OpW-1:0] OP_INS_BEFORE = 3'd2;
    localparam logic [OpW-1:0] OP_DELETE = 3'd3;
    localparam logic [OpW-1:0] OP_LIST = 3'd4;

    localparam logic [StatW-1:0] ST_OK = 2'd0;
    localparam logic [StatW-1:0] ST_FULL = 2'd1;
    localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [OpW-1:0] op;
        logic signed [ValW-1:0] key;
        logic signed [ValW-1:0] new_value;
    } t_in_word;

    typedef struct packed {
        logic signed [ValW-1:0] item_value;
        logic [StatW-1:0] status;
        logic last;
    } t_out_word;
endpackage

[hw/rtl/alle_if.sv]
// Valid/ready channel interface carrying one word of type T.
// The word type T is a parameter; this file imports no package.
interface alle_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/alle_store.sv]
// Node store: value and link memories, one write and one registered read port.
// Depends on alle_pkg.
module alle_store import alle_pkg::*; #(
    parameter int NODE_COUNT = NodeCountDef
) (
    input  logic i_clk,
    input  logic i_we,
    input  logic [$clog2(NODE_COUNT)-1:0] i_waddr,
    input  logic i_wval_en,
    input  logic [ValW-1:0] i_wval,
    input  logic i_wnext_en,
    input  logic [LinkW-1:0] i_wnext,
    input  logic [$clog2(NODE_COUNT)-1:0] i_raddr,
    output logic [ValW-1:0] o_rval,
    output logic [LinkW-1:0] o_rnext
);
    logic [ValW-1:0] r_val_mem [NODE_COUNT];
    logic [LinkW-1:0] r_next_mem [NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we && i_wval_en) begin
            r_val_mem[i_waddr] <= i_wval;
        end
        if (i_we && i_wnext_en) begin
            r_next_mem[i_waddr] <= i_wnext;
        end
        o_rval <= r_val_mem[i_raddr];
        o_rnext <= r_next_mem[i_raddr];
    end
endmodule

[hw/rtl/array_linked_list_engine_core.sv]
// Append scans the occupancy map for a free slot; searches walk the list from the head,
// reading one node at a time; list gives one output word per node walked.
// One operation at a time: a new command is accepted only in idle with no output word
// pending; the node store has a single read port.
// Reset: synchronous active-low; clears the occupancy map, head, tail and count.
// Node memories are not cleared; only written nodes are ever read.
module array_linked_list_engine_core import alle_pkg::*; #(
    parameter int NODE_COUNT = NodeCountDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    alle_if.sink   i_in,
    alle_if.source o_out
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam logic [LinkW-1:0] NodeMax = LinkW'(NODE_COUNT);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_RD = 8'b0000_0100,
        S_CHK = 8'b0000_1000,
        S_MOD = 8'b0001_0000,
        S_FIX = 8'b0010_0000,
        S_OUT = 8'b0100_0000,
        S_LWAIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_in_word r_cmd, n_cmd;
    logic [NODE_COUNT-1:0] r_used, n_used;
    logic [LinkW-1:0] r_head, n_head, r_tail, n_tail, r_cnt, n_cnt;
    logic [LinkW-1:0] r_cur, n_cur, r_prev, n_prev, r_slot, n_slot;
    logic [LinkW-1:0] r_steps, n_steps, r_curnext, n_curnext;
    logic r_ov, n_ov;
    t_out_word r_ow, n_ow;
    logic r_fixpend, n_fixpend;
    logic [LinkW-1:0] r_fixaddr, n_fixaddr, r_fixnext, n_fixnext;

    logic we, wval_en, wnext_en;
    logic [AW-1:0] waddr, raddr;
    logic [ValW-1:0] wval, rval;
    logic [LinkW-1:0] wnext, rnext;

    alle_store #(.NODE_COUNT(NODE_COUNT)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wval_en(wval_en), .i_wval(wval),
        .i_wnext_en(wnext_en), .i_wnext(wnext), .i_raddr(raddr),
        .o_rval(rval), .o_rnext(rnext)
    );

    assign i_in.ready = (r_state == S_IDLE) && !r_ov;
    assign o_out.valid = r_ov;
    assign o_out.data = r_ow;

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_used = r_used; n_head = r_head;
        n_tail = r_tail; n_cnt = r_cnt; n_cur = r_cur; n_prev = r_prev;
        n_slot = r_slot; n_steps = r_steps; n_curnext = r_curnext;
        n_ov = r_ov && !o_out.ready; n_ow = r_ow;
        n_fixpend = 1'b0; n_fixaddr = r_fixaddr; n_fixnext = r_fixnext;
        we = 1'b0; wval_en = 1'b0; wnext_en = 1'b0;
        waddr = r_slot[AW-1:0]; wval = r_cmd.new_value; wnext = NullSlot;
        raddr = r_cur[AW-1:0];
        if (r_fixpend) begin
            we = 1'b1; wnext_en = 1'b1; waddr = r_fixaddr[AW-1:0]; wnext = r_fixnext;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in.valid && !r_ov) begin
                    n_cmd = i_in.data;
                    n_cur = r_head; n_prev = NullSlot; n_steps = '0; n_slot = '0;
                    n_ow = '{item_value: '0, status: ST_OK, last: 1'b1};
                    case (i_in.data.op)
                        OP_APPEND: begin
                            if (r_cnt >= NodeMax) begin
                                n_ow.status = ST_FULL; n_ov = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_INS_AFTER, OP_INS_BEFORE, OP_DELETE, OP_LIST: begin
                            if (r_head >= NodeMax) begin
                                n_ow.status = (i_in.data.op == OP_LIST) ? ST_EMPTY
                                                                        : ST_NOT_FOUND;
                                n_ov = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_used[r_slot[AW-1:0]]) begin
                    n_state = S_MOD;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (r_cmd.op == OP_LIST && r_ov) begin
                    n_state = S_CHK;
                end else begin
                    n_curnext = rnext;
                    n_steps = r_steps + 1'b1;
                    if (r_cmd.op == OP_LIST) begin
                        n_ow.item_value = rval;
                        n_ow.last = (rnext >= NodeMax) || (n_steps == NodeMax);
                        n_state = S_OUT;
                    end else if (rval == r_cmd.key) begin
                        if (r_cmd.op == OP_DELETE) begin
                            n_state = S_MOD;
                        end else if (r_cnt >= NodeMax) begin
                            n_ow.status = ST_FULL; n_ov = 1'b1; n_state = S_LWAIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if ((rnext >= NodeMax) || (n_steps == NodeMax)) begin
                        n_ow.status = ST_NOT_FOUND; n_ov = 1'b1; n_state = S_LWAIT;
                    end else begin
                        n_prev = r_cur; n_cur = rnext; n_state = S_RD;
                    end
                end
            end
            S_OUT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    if (r_ow.last) begin
                        n_state = S_LWAIT;
                    end else begin
                        n_cur = r_curnext; n_state = S_RD;
                    end
                end
            end
            S_MOD: begin
                n_ow = '{item_value: '0, status: ST_OK, last: 1'b1};
                n_ov = 1'b1; n_state = S_LWAIT;
                case (r_cmd.op)
                    OP_APPEND: begin
                        we = 1'b1; wval_en = 1'b1; wnext_en = 1'b1; wnext = NullSlot;
                        n_used[r_slot[AW-1:0]] = 1'b1; n_cnt = r_cnt + 1'b1;
                        if (r_head >= NodeMax || r_tail >= NodeMax) begin
                            n_head = r_slot;
                        end else begin
                            n_fixpend = 1'b1; n_fixaddr = r_tail; n_fixnext = r_slot;
                        end
                        n_tail = r_slot;
                    end
                    OP_INS_AFTER: begin
                        we = 1'b1; wval_en = 1'b1; wnext_en = 1'b1; wnext = r_curnext;
                        n_used[r_slot[AW-1:0]] = 1'b1; n_cnt = r_cnt + 1'b1;
                        n_fixpend = 1'b1; n_fixaddr = r_cur; n_fixnext = r_slot;
                        if (r_tail == r_cur) n_tail = r_slot;
                    end
                    OP_INS_BEFORE: begin
                        we = 1'b1; wval_en = 1'b1; wnext_en = 1'b1; wnext = r_cur;
                        n_used[r_slot[AW-1:0]] = 1'b1; n_cnt = r_cnt + 1'b1;
                        if (r_prev >= NodeMax) begin
                            n_head = r_slot;
                        end else begin
                            n_fixpend = 1'b1; n_fixaddr = r_prev; n_fixnext = r_slot;
                        end
                    end
                    OP_DELETE: begin
                        if (r_prev >= NodeMax) begin
                            n_head = r_curnext;
                        end else begin
                            n_fixpend = 1'b1; n_fixaddr = r_prev; n_fixnext = r_curnext;
                        end
                        if (r_tail == r_cur) n_tail = r_prev;
                        n_used[r_cur[AW-1:0]] = 1'b0; n_cnt = r_cnt - 1'b1;
                    end
                    default: ;
                endcase
            end
            S_LWAIT: begin
                if (!n_ov) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_head <= NullSlot; r_tail <= NullSlot;
            r_cnt <= '0; r_ov <= 1'b0; r_fixpend <= 1'b0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_head <= n_head; r_tail <= n_tail;
            r_cnt <= n_cnt; r_ov <= n_ov; r_fixpend <= n_fixpend;
        end
        r_cmd <= n_cmd; r_cur <= n_cur; r_prev <= n_prev; r_slot <= n_slot;
        r_steps <= n_steps; r_curnext <= n_curnext; r_ow <= n_ow;
        r_fixaddr <= n_fixaddr; r_fixnext <= n_fixnext;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NodeMax) else $error("count exceeds store");
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == LinkW'($countones(r_used))) else $error("count and map disagree");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_head == NullSlot || r_state != S_IDLE))
        else $error("empty store with head");
`endif
endmodule
